[sv/ppg_pkg.sv]
package ppg_pkg;

  localparam int unsigned MaxSideDefault = 1024;
  localparam int unsigned CoordW = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE  = 3'd0,
    REG_COUNT = 3'd1,
    REG_PIX   = 3'd2,
    REG_RED   = 3'd3,
    REG_GREEN = 3'd4,
    REG_BLUE  = 3'd5,
    REG_ALPHA = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_GRID  = 2'd0,
    MODE_HORIZ = 2'd1,
    MODE_VERT  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

endpackage

[sv/ppg_divmod.sv]
// Pipelined unsigned divide of an NW-bit value by a DW-bit divisor.
// One quotient bit per stage; remainder and quotient out after NW stages.
module ppg_divmod #(
  parameter int unsigned NW = 10,
  parameter int unsigned DW = 12
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  // stage k holds partial remainder, remaining numerator bits, quotient
  logic [DW:0]   rem_r [NW+1];
  logic [NW-1:0] num_r [NW+1];
  logic [NW-1:0] quo_r [NW+1];
  logic [DW-1:0] den_r [NW+1];

  always_comb begin
    rem_r[0] = '0;
    num_r[0] = num;
    quo_r[0] = '0;
    den_r[0] = den;
  end

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW:0] sh;
    logic        ge;
    assign sh = {rem_r[k][DW-1:0], num_r[k][NW-1]};
    assign ge = sh >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? (sh - {1'b0, den_r[k]}) : sh;
      num_r[k+1] <= {num_r[k][NW-2:0], 1'b0};
      quo_r[k+1] <= {quo_r[k][NW-2:0], ge};
      den_r[k+1] <= den_r[k];
    end
  end

  assign quo = quo_r[NW];
  assign rem = rem_r[NW][DW-1:0];
endmodule

[sv/plank_pattern_pixel_generator.sv]
// Channel | Ports                                         | Dir
// input   | start, in_pixel_x, in_pixel_y (busy is out) | in
// result  | out_valid, out_red/green/blue/alpha, out_inside_tile | out
// config  | cfg_we, cfg_index, cfg_data                   | in
// One word accepted per cycle; busy is held low. A result passes the
// input register, 10-stage row divider, edge stage, 12-stage column
// divider and output register.
// rst_n is synchronous; it clears the config registers, the valid pipe and out_valid.
// The receiver cannot stall; results are shown for one cycle on out_valid.
module plank_pattern_pixel_generator #(
  parameter int unsigned MAX_SIDE = ppg_pkg::MaxSideDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ppg_pkg::CoordW-1:0]     in_pixel_x,
  input  logic [ppg_pkg::CoordW-1:0]     in_pixel_y,
  input  logic                           cfg_we,
  input  logic [ppg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ppg_pkg::CfgDataW-1:0]   cfg_data,
  output logic                           out_valid,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_inside_tile
);
  localparam int unsigned CW = ppg_pkg::CoordW;
  localparam int unsigned DW = 12;          // 24*127 fits 12 bits
  localparam int unsigned SW = 16;          // cell_count*cell_pixels
  localparam int unsigned LAT = 2 * CW + 4;

  logic [1:0] mode_r;
  logic [8:0] count_r;
  logic [6:0] pix_r;
  logic [7:0] red_r, green_r, blue_r, alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ppg_pkg::MODE_GRID; count_r <= 9'd36; pix_r <= 7'd5;
      red_r <= 8'd40; green_r <= 8'd40; blue_r <= 8'd40; alpha_r <= 8'd38;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppg_pkg::REG_MODE:  mode_r  <= cfg_data[1:0];
        ppg_pkg::REG_COUNT: count_r <= cfg_data[8:0];
        ppg_pkg::REG_PIX:   pix_r   <= cfg_data[6:0];
        ppg_pkg::REG_RED:   red_r   <= cfg_data[7:0];
        ppg_pkg::REG_GREEN: green_r <= cfg_data[7:0];
        ppg_pkg::REG_BLUE:  blue_r  <= cfg_data[7:0];
        ppg_pkg::REG_ALPHA: alpha_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Derived config values, registered (config is static while in use).
  logic [SW-1:0] prod;
  logic [SW:0]   side_r;
  logic [DW-1:0] ph_r, pw_r, half_r;
  logic          thick2_r;
  assign prod = SW'(count_r) * SW'(pix_r);
  always_ff @(posedge clk) begin
    side_r   <= (prod > SW'(MAX_SIDE)) ? (SW+1)'(MAX_SIDE) : {1'b0, prod};
    ph_r     <= DW'(pix_r) * DW'(3);
    pw_r     <= DW'(pix_r) * DW'(24);
    half_r   <= DW'(pix_r) * DW'(12);
    thick2_r <= pix_r > 7'd7;
  end

  // Stage 0: map to (u along plank, v across).
  logic [LAT-1:0] vld_r;
  logic [CW-1:0]  u0_r, v0_r, x0_r, y0_r;
  logic [1:0]     m0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LAT-2:0], start};
    u0_r <= (mode_r == ppg_pkg::MODE_VERT) ? in_pixel_y : in_pixel_x;
    v0_r <= (mode_r == ppg_pkg::MODE_VERT) ? in_pixel_x : in_pixel_y;
    x0_r <= in_pixel_x; y0_r <= in_pixel_y; m0_r <= mode_r;
  end

  // Row divide: v / ph, v % ph.
  logic [CW-1:0] vq;
  logic [DW-1:0] vr;
  ppg_divmod #(.NW(CW), .DW(DW)) u_vdiv (
    .clk(clk), .num(v0_r), .den(ph_r), .quo(vq), .rem(vr));

  // Carry side data along the first divider.
  logic [CW-1:0] ud_r [CW], vd_r [CW], xd_r [CW], yd_r [CW];
  logic [1:0]    md_r [CW];
  always_ff @(posedge clk) begin
    ud_r[0] <= u0_r; vd_r[0] <= v0_r; xd_r[0] <= x0_r; yd_r[0] <= y0_r;
    md_r[0] <= m0_r;
    for (int i = 1; i < CW; i++) begin
      ud_r[i] <= ud_r[i-1]; vd_r[i] <= vd_r[i-1]; xd_r[i] <= xd_r[i-1];
      yd_r[i] <= yd_r[i-1]; md_r[i] <= md_r[i-1];
    end
  end

  // Stage A: row edge flags, stagger offset, column dividend.
  logic          rowe_r, inside_r;
  logic [1:0]    ma_r;
  logic [CW-1:0] ua_r, xa_r, ya_r;
  logic [CW+1:0] ue_r;   // u + off, up to 1023 + 1524
  logic [DW-1:0] ua_ph;
  logic [CW-1:0] va;
  logic          vr_first, vr_last, v_last, v_in;
  logic          vm_first, vm_last, vm_lastside, vm_in, rowe_a;
  assign va = vd_r[CW-1];
  assign vr_first = vr == '0;
  assign vr_last  = (vr + DW'(1)) == ph_r;
  assign v_in     = {1'b0, va} < side_r;
  assign v_last   = ({1'b0, va} + (CW+1)'(1)) == side_r[CW:0] && side_r[SW:CW+1] == '0;
  // previous row v-1: remainder of v-1 derived from vr
  assign vm_first = vr == DW'(1);
  assign vm_last  = vr_first;
  assign vm_lastside = {1'b0, va} == side_r[CW:0] && side_r[SW:CW+1] == '0;
  assign vm_in = (va != '0);
  assign rowe_a = (v_in && (vr_first || vr_last || v_last)) ||
                  (thick2_r && vm_in && (vm_first || vm_last || vm_lastside));
  assign ua_ph = '0;
  always_ff @(posedge clk) begin
    rowe_r   <= rowe_a;
    ua_r     <= ud_r[CW-1];
    ue_r     <= (CW+2)'({2'b0, ud_r[CW-1]} + (vq[0] ? half_r : ua_ph));
    xa_r     <= xd_r[CW-1]; ya_r <= yd_r[CW-1]; ma_r <= md_r[CW-1];
    inside_r <= ({1'b0, xd_r[CW-1]} < side_r) && ({1'b0, yd_r[CW-1]} < side_r);
  end

  // Column divide of (u + off) by pw; the dividend fits 12 bits.
  logic [CW+1:0] uq;
  logic [DW-1:0] ur;
  ppg_divmod #(.NW(CW+2), .DW(DW)) u_udiv (
    .clk(clk), .num(ue_r), .den(pw_r), .quo(uq), .rem(ur));

  logic          rowe_d [CW+2], ins_d [CW+2];
  logic [CW-1:0] ub_d [CW+2], xb_d [CW+2], yb_d [CW+2];
  logic [1:0]    mb_d [CW+2];
  always_ff @(posedge clk) begin
    rowe_d[0] <= rowe_r; ins_d[0] <= inside_r; ub_d[0] <= ua_r;
    xb_d[0] <= xa_r; yb_d[0] <= ya_r; mb_d[0] <= ma_r;
    for (int i = 1; i <= CW + 1; i++) begin
      rowe_d[i] <= rowe_d[i-1]; ins_d[i] <= ins_d[i-1]; ub_d[i] <= ub_d[i-1];
      xb_d[i] <= xb_d[i-1]; yb_d[i] <= yb_d[i-1]; mb_d[i] <= mb_d[i-1];
    end
  end

  // Final stage: column edges and colour select.
  logic [CW-1:0] ub, xb, yb;
  logic          u_in, u_last, um_in, um_lastside, cole, lit, plank;
  logic [1:0]    mb;
  assign ub = ub_d[CW+1];
  assign xb = xb_d[CW+1];
  assign yb = yb_d[CW+1];
  assign mb = mb_d[CW+1];
  assign u_in   = {1'b0, ub} < side_r;
  assign u_last = ({1'b0, ub} + (CW+1)'(1)) == side_r[CW:0] && side_r[SW:CW+1] == '0;
  assign um_in  = ub != '0;
  assign um_lastside = {1'b0, ub} == side_r[CW:0] && side_r[SW:CW+1] == '0;
  // x edge: r==0 or r==pw-1; x-1 edge: r==1 or r==0 (i.e. (x+off)%pw==0)
  assign cole = (u_in && (ub == '0 || u_last || ur == '0 ||
                          (ur + DW'(1)) == pw_r)) ||
                (thick2_r && um_in && (ub == CW'(1) || um_lastside ||
                                       ur == DW'(1) || ur == '0));
  assign plank = rowe_d[CW+1] || cole;
  always_comb begin
    case (mb) inside
      ppg_pkg::MODE_GRID:  lit = (xb == '0) || (yb == '0) ||
                                 (thick2_r && (xb == CW'(1) || yb == CW'(1)));
      ppg_pkg::MODE_HORIZ,
      ppg_pkg::MODE_VERT:  lit = plank;
      default:             lit = 1'b0;
    endcase
    lit = lit && ins_d[CW+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vld_r[LAT-1];
    out_red   <= lit ? red_r   : '0;
    out_green <= lit ? green_r : '0;
    out_blue  <= lit ? blue_r  : '0;
    out_alpha <= lit ? alpha_r : '0;
    out_inside_tile <= ins_d[CW+1];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_tile |-> out_alpha == '0 && out_red == '0)
    else $error("color outside tile");
  assert property (@(posedge clk) disable iff (!rst_n)
    busy == 1'b0) else $error("busy asserted");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[LAT-1])) else $error("valid pipe slip");
endmodule
